>>> sv/sabc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabc_pkg
// Types, message codes and register indexes shared by the alarm bus controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sabc_pkg;

    // Run length and widths
    localparam int MAX_RES   = 5;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Event codes
    localparam logic [2:0] ACT_BUS_ALARM = 3'd0;
    localparam logic [2:0] ACT_BUS_TEST  = 3'd1;
    localparam logic [2:0] ACT_RESET     = 3'd2;
    localparam logic [2:0] ACT_STATUS    = 3'd3;
    localparam logic [2:0] ACT_BUTTON    = 3'd4;
    localparam logic [2:0] ACT_SECOND    = 3'd5;
    localparam logic [2:0] ACT_MINUTE    = 3'd6;
    localparam logic [2:0] ACT_CHECK     = 3'd7;

    // Message kinds
    localparam logic [3:0] MSG_NONE         = 4'd0;
    localparam logic [3:0] MSG_ALARM_NET    = 4'd1;
    localparam logic [3:0] MSG_ALARM_STATUS = 4'd2;
    localparam logic [3:0] MSG_TEST_NET     = 4'd3;
    localparam logic [3:0] MSG_TEST_STATUS  = 4'd4;
    localparam logic [3:0] MSG_RESET        = 4'd5;
    localparam logic [3:0] MSG_DELAYED      = 4'd6;
    localparam logic [3:0] MSG_RESET_VALUE  = 4'd7;
    localparam logic [3:0] MSG_CHECK        = 4'd8;

    // Check answers
    localparam logic [1:0] CHK_NO_CHANGE = 2'd0;
    localparam logic [1:0] CHK_ALARM     = 2'd1;
    localparam logic [1:0] CHK_TEST      = 2'd2;
    localparam logic [1:0] CHK_STOP      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DELAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_FLAGS     = 2'd3;

    // send_flags bits
    localparam int SF_DELAYED   = 0;
    localparam int SF_STATUS    = 1;
    localparam int SF_NETWORK   = 2;
    localparam int SF_IDLE      = 3;
    localparam int SF_TEST      = 4;
    localparam int SF_TEST_NET  = 5;

    // Reset values
    localparam logic [15:0] ALARM_INTERVAL_RST = 16'd60;
    localparam logic [15:0] TEST_INTERVAL_RST  = 16'd60;

    // Bus bit mask on received value
    localparam logic BUS_BIT = 1'b1;

    typedef struct packed {
        logic [2:0] action;
        logic       bus_value;
        logic       alarm_local;
        logic       test_alarm_local;
        logic       alarm_from_bus;
        logic       test_alarm_from_bus;
    } t_in;

    typedef struct packed {
        logic [3:0] message_kind;
        logic       message_value;
        logic [1:0] check_answer;
        logic       any_alarm;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [3:0] kind;
        logic       value;
        logic [1:0] answer;
    } t_msg;

    // One event's whole answer
    typedef struct packed {
        t_msg [MAX_RES-1:0] msg;
        logic [CNT_W-1:0]   count;
        logic               any_alarm;
    } t_run;

endpackage

`default_nettype wire

>>> sv/smoke_alarm_bus_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoke_alarm_bus_controller_unit
// Alarm controller of a networked smoke detector: one event in, a run of
// one to five bus messages out.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                            Beat
//  event     in   i_in_valid / o_in_ready / i_in     one event
//  message   out  o_out_valid / i_out_ready / o_out  one message, last on final
//  config    in   i_cfg_we / i_cfg_idx / i_cfg_data  one register write
//
//  An event is evaluated in the cycle it is accepted; its run is registered
//  and then sent one message per cycle while the output is ready; a run
//  holds as many messages as its event caused (1 to 5).
//  Two run slots (pending and sending) let the next event in while a run is
//  still going out; a stalled output holds both.
//  Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module smoke_alarm_bus_controller_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sabc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sabc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire sabc_pkg::t_in                    i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output sabc_pkg::t_out                        o_out
);
    import sabc_pkg::*;

    logic w_run_valid, w_run_take;
    t_run w_run;

    sabc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_run_valid (w_run_valid),
        .i_run_take  (w_run_take),
        .o_run       (w_run)
    );

    sabc_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (w_run_valid),
        .o_run_take  (w_run_take),
        .i_run       (w_run),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> sv/sabc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabc_core
// Alarm state, registers and counters; builds the message run of each event.
// ----------------------------------------------------------------------------
`default_nettype none

module sabc_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sabc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sabc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire sabc_pkg::t_in                    i_in,
    output logic                                  o_run_valid,
    input  wire logic                             i_run_take,
    output sabc_pkg::t_run                        o_run
);
    import sabc_pkg::*;

    function automatic t_msg f_msg(logic [3:0] k, logic v, logic [1:0] a);
        t_msg m;
        m.kind   = k;
        m.value  = v;
        m.answer = a;
        return m;
    endfunction

    // append one message, dropping anything beyond the run length
    function automatic t_run f_push(t_run r, t_msg m);
        t_run q;
        q = r;
        if (r.count < CNT_W'(MAX_RES)) begin
            q.msg[r.count] = m;
            q.count        = r.count + CNT_W'(1);
        end
        return q;
    endfunction

    // Configuration registers
    logic [15:0] r_alarm_interval, r_test_interval;
    logic [7:0]  r_alarm_delay;
    logic [5:0]  r_send_flags;

    // Event state
    logic r_la, r_ba, r_lt, r_bt, r_wa, r_wt, r_ig, r_ds;
    logic [15:0] r_nc, r_sc, r_tc;
    logic [7:0]  r_dc;

    logic r_run_valid;
    t_run r_run;

    logic w_accept;
    logic n_la, n_ba, n_lt, n_bt, n_wa, n_wt, n_ig, n_ds;
    logic [15:0] n_nc, n_sc, n_tc;
    logic [7:0]  n_dc;
    t_run n_run;

    assign o_in_ready  = !r_run_valid || i_run_take;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_run_valid = r_run_valid;
    assign o_run       = r_run;

    // Event evaluation, in the order the messages go out
    always_comb begin
        logic       v_on;
        logic [7:0] v_dnew;
        logic [1:0] v_ans;
        logic       v_bv;

        n_la = r_la; n_ba = r_ba; n_lt = r_lt; n_bt = r_bt;
        n_wa = r_wa; n_wt = r_wt; n_ig = r_ig; n_ds = r_ds;
        n_nc = r_nc; n_sc = r_sc; n_tc = r_tc; n_dc = r_dc;
        n_run  = '0;
        v_on   = 1'b0;
        v_dnew = '0;
        v_ans  = CHK_NO_CHANGE;
        v_bv   = (i_in.bus_value & BUS_BIT) != 1'b0;

        unique case (i_in.action)
            ACT_BUS_ALARM: begin
                n_wa = v_bv;
                if (!v_bv && r_la && r_dc == 8'd0) begin
                    n_nc  = r_alarm_interval;
                    n_run = f_push(n_run, f_msg(MSG_ALARM_NET, r_la, CHK_NO_CHANGE));
                end
                if (r_ig) n_wa = 1'b0;
            end
            ACT_BUS_TEST: begin
                n_wt = v_bv;
                if (!v_bv && r_lt)
                    n_run = f_push(n_run, f_msg(MSG_TEST_NET, r_lt, CHK_NO_CHANGE));
                if (r_ig) n_wt = 1'b0;
            end
            ACT_RESET: begin
                n_wa = 1'b0;
                n_wt = 1'b0;
                n_ig = 1'b1;
                n_dc = '0;
                if (r_ds) begin
                    n_ds  = 1'b0;
                    n_run = f_push(n_run, f_msg(MSG_DELAYED, 1'b0, CHK_NO_CHANGE));
                end
            end
            ACT_STATUS: begin
                if (r_la != i_in.alarm_local) begin
                    n_la = i_in.alarm_local;
                    // delayed start only for a rising alarm with the flag set
                    if (i_in.alarm_local && r_send_flags[SF_DELAYED]) begin
                        v_dnew = r_alarm_delay;
                    end else begin
                        v_dnew = '0;
                    end
                    v_on = v_dnew != 8'd0;
                    n_dc = v_dnew;
                    if (v_on != r_ds) begin
                        n_ds  = v_on;
                        n_run = f_push(n_run, f_msg(MSG_DELAYED, v_on, CHK_NO_CHANGE));
                    end
                    if (!(i_in.alarm_local && r_send_flags[SF_DELAYED])) begin
                        n_nc  = r_alarm_interval;
                        n_run = f_push(n_run, f_msg(MSG_ALARM_NET, n_la, CHK_NO_CHANGE));
                    end
                    n_sc  = r_alarm_interval;
                    n_run = f_push(n_run, f_msg(MSG_ALARM_STATUS, n_la, CHK_NO_CHANGE));
                end
                if (r_lt != i_in.test_alarm_local) begin
                    n_lt  = i_in.test_alarm_local;
                    n_run = f_push(n_run, f_msg(MSG_TEST_NET, n_lt, CHK_NO_CHANGE));
                    n_tc  = r_test_interval;
                    n_run = f_push(n_run, f_msg(MSG_TEST_STATUS, n_lt, CHK_NO_CHANGE));
                end
                n_ba = i_in.alarm_from_bus;
                n_bt = i_in.test_alarm_from_bus;
            end
            ACT_BUTTON: begin
                if (r_wa || r_wt) begin
                    n_wa = 1'b0;
                    n_wt = 1'b0;
                    n_ig = 1'b1;
                    n_dc = '0;
                    if (r_ds) begin
                        n_ds  = 1'b0;
                        n_run = f_push(n_run, f_msg(MSG_DELAYED, 1'b0, CHK_NO_CHANGE));
                    end
                    n_run = f_push(n_run, f_msg(MSG_RESET, 1'b1, CHK_NO_CHANGE));
                end
            end
            ACT_SECOND: begin
                if (r_la) begin
                    if (r_dc != 8'd0) begin
                        // alarm delay running down
                        v_dnew = r_dc - 8'd1;
                        v_on   = v_dnew != 8'd0;
                        n_dc   = v_dnew;
                        if (v_on != r_ds) begin
                            n_ds  = v_on;
                            n_run = f_push(n_run, f_msg(MSG_DELAYED, v_on, CHK_NO_CHANGE));
                        end
                        if (!v_on) begin
                            n_nc  = r_alarm_interval;
                            n_run = f_push(n_run, f_msg(MSG_ALARM_NET, r_la, CHK_NO_CHANGE));
                        end
                    end else if (r_send_flags[SF_STATUS]) begin
                        n_sc = r_sc - 16'd1;
                        if (n_sc == 16'd0) begin
                            n_sc  = r_alarm_interval;
                            n_run = f_push(n_run,
                                           f_msg(MSG_ALARM_STATUS, r_la, CHK_NO_CHANGE));
                        end
                        if (r_send_flags[SF_NETWORK]) begin
                            n_nc = r_nc - 16'd1;
                            if (n_nc == 16'd0) begin
                                n_nc  = r_alarm_interval;
                                n_run = f_push(n_run,
                                               f_msg(MSG_ALARM_NET, r_la, CHK_NO_CHANGE));
                            end
                        end
                    end
                end else if (r_send_flags[SF_IDLE]) begin
                    n_sc = r_sc - 16'd1;
                    if (n_sc == 16'd0) begin
                        n_sc  = r_alarm_interval;
                        n_run = f_push(n_run, f_msg(MSG_ALARM_STATUS, r_la, CHK_NO_CHANGE));
                    end
                end
                // periodic test alarm resend
                if (r_lt && r_send_flags[SF_TEST]) begin
                    n_tc = r_tc - 16'd1;
                    if (n_tc == 16'd0) begin
                        if (r_send_flags[SF_TEST_NET])
                            n_run = f_push(n_run, f_msg(MSG_TEST_NET, r_lt, CHK_NO_CHANGE));
                        n_tc  = r_test_interval;
                        n_run = f_push(n_run, f_msg(MSG_TEST_STATUS, r_lt, CHK_NO_CHANGE));
                    end
                end
            end
            ACT_MINUTE: begin
                if (r_ig && !(r_ba || r_bt)) begin
                    n_ig  = 1'b0;
                    n_run = f_push(n_run, f_msg(MSG_RESET_VALUE, 1'b0, CHK_NO_CHANGE));
                end
            end
            ACT_CHECK: begin
                priority if (r_wa) begin
                    v_ans = r_ba ? CHK_NO_CHANGE : CHK_ALARM;
                end else if (r_wt) begin
                    v_ans = r_bt ? CHK_NO_CHANGE : CHK_TEST;
                end else if (r_ba || r_bt) begin
                    v_ans = CHK_STOP;
                end else begin
                    v_ans = CHK_NO_CHANGE;
                end
                n_run = f_push(n_run, f_msg(MSG_CHECK, 1'b0, v_ans));
            end
            default: ;
        endcase

        // an event with nothing to send answers with one 'none'
        if (n_run.count == '0)
            n_run = f_push(n_run, f_msg(MSG_NONE, 1'b0, CHK_NO_CHANGE));
        n_run.any_alarm = n_la || n_ba || n_lt || n_bt;
    end

    // State, registers and the run slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_interval <= ALARM_INTERVAL_RST;
            r_test_interval  <= TEST_INTERVAL_RST;
            r_alarm_delay    <= '0;
            r_send_flags     <= '0;
            r_la <= 1'b0; r_ba <= 1'b0; r_lt <= 1'b0; r_bt <= 1'b0;
            r_wa <= 1'b0; r_wt <= 1'b0; r_ig <= 1'b0; r_ds <= 1'b0;
            r_nc <= ALARM_INTERVAL_RST;
            r_sc <= ALARM_INTERVAL_RST;
            r_tc <= TEST_INTERVAL_RST;
            r_dc <= '0;
            r_run_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_la <= n_la; r_ba <= n_ba; r_lt <= n_lt; r_bt <= n_bt;
                r_wa <= n_wa; r_wt <= n_wt; r_ig <= n_ig; r_ds <= n_ds;
                r_nc <= n_nc; r_sc <= n_sc; r_tc <= n_tc; r_dc <= n_dc;
                r_run       <= n_run;
                r_run_valid <= 1'b1;
            end else if (i_run_take) begin
                r_run_valid <= 1'b0;
            end
            // register writes; interval writes reload their counters
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALARM_INTERVAL: begin
                        r_alarm_interval <= i_cfg_data;
                        r_nc             <= i_cfg_data;
                        r_sc             <= i_cfg_data;
                    end
                    CFG_TEST_INTERVAL: begin
                        r_test_interval <= i_cfg_data;
                        r_tc            <= i_cfg_data;
                    end
                    CFG_ALARM_DELAY: r_alarm_delay <= i_cfg_data[7:0];
                    CFG_SEND_FLAGS:  r_send_flags  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/sabc_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabc_serializer
// Holds the run being sent and puts its messages out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sabc_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_run_valid,
    output logic                 o_run_take,
    input  wire sabc_pkg::t_run  i_run,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sabc_pkg::t_out       o_out
);
    import sabc_pkg::*;

    t_run             r_cur;
    logic             r_cur_valid;
    logic [CNT_W-1:0] r_idx;

    logic w_last, w_done;
    t_msg w_msg;

    assign w_last     = r_idx == CNT_W'(r_cur.count - CNT_W'(1));
    assign w_done     = r_cur_valid && i_out_ready && w_last;
    assign o_run_take = i_run_valid && (!r_cur_valid || w_done);

    // Current message
    assign w_msg       = r_cur.msg[r_idx];
    assign o_out_valid = r_cur_valid;
    assign o_out       = '{message_kind:  w_msg.kind,
                           message_value: w_msg.value,
                           check_answer:  w_msg.answer,
                           any_alarm:     r_cur.any_alarm,
                           last:          w_last};

    // Run slot and beat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_run_take) begin
                r_cur       <= i_run;
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (w_done) begin
                r_cur_valid <= 1'b0;
            end else if (r_cur_valid && i_out_ready) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/smoke_alarm_bus_controller_unit_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoke_alarm_bus_controller_unit_monitor
// Watches the event, message and register ports of the alarm bus controller.
// It keeps its own copy of the alarm state and register values, works out the
// message run of each accepted event and checks every message beat against
// the oldest one awaited.
// ----------------------------------------------------------------------------

module smoke_alarm_bus_controller_unit_monitor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sabc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sabc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire sabc_pkg::t_in                    i_in,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire sabc_pkg::t_out                   i_out,
    output int                                    o_fail_count,
    output int                                    o_outstanding
);
    import sabc_pkg::*;

    // Register copies
    logic [15:0] alarm_ival;
    logic [15:0] test_ival;
    logic [7:0]  delay_set;
    logic [5:0]  flag_bits;

    // Alarm state
    logic        lcl_alarm, bus_alarm_f, lcl_test, bus_test_f;
    logic        req_alarm, req_test, ignore_bus, delay_shown;
    logic [15:0] net_cnt, stat_cnt, test_cnt;
    logic [7:0]  delay_cnt;

    t_msg run_buf[$];        // messages of the event being worked out
    t_out awaited_msgs[$];   // message beats still to come from the block
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void restore_defaults();
        alarm_ival  = ALARM_INTERVAL_RST;
        test_ival   = TEST_INTERVAL_RST;
        delay_set   = 8'd0;
        flag_bits   = 6'd0;
        lcl_alarm   = 1'b0;
        bus_alarm_f = 1'b0;
        lcl_test    = 1'b0;
        bus_test_f  = 1'b0;
        req_alarm   = 1'b0;
        req_test    = 1'b0;
        ignore_bus  = 1'b0;
        delay_shown = 1'b0;
        net_cnt     = ALARM_INTERVAL_RST;
        stat_cnt    = ALARM_INTERVAL_RST;
        test_cnt    = TEST_INTERVAL_RST;
        delay_cnt   = 8'd0;
    endfunction

    function automatic void add_msg(input logic [3:0] kind, input logic val,
                                   input logic [1:0] ans);
        t_msg m;
        if (run_buf.size() < MAX_RES) begin
            m.kind   = kind;
            m.value  = val;
            m.answer = ans;
            run_buf.push_back(m);
        end
    endfunction

    // Delay counter; the delayed message goes out only when its shown state flips
    function automatic void set_delay(input logic [7:0] v);
        logic shown_now;
        shown_now = (v != 8'd0);
        delay_cnt = v;
        if (shown_now != delay_shown) begin
            delay_shown = shown_now;
            add_msg(MSG_DELAYED, shown_now, CHK_NO_CHANGE);
        end
    endfunction

    function automatic void send_alarm_net();
        net_cnt = alarm_ival;
        add_msg(MSG_ALARM_NET, lcl_alarm, CHK_NO_CHANGE);
    endfunction

    function automatic void send_alarm_status();
        stat_cnt = alarm_ival;
        add_msg(MSG_ALARM_STATUS, lcl_alarm, CHK_NO_CHANGE);
    endfunction

    function automatic void send_test_net();
        add_msg(MSG_TEST_NET, lcl_test, CHK_NO_CHANGE);
    endfunction

    function automatic void send_test_status();
        test_cnt = test_ival;
        add_msg(MSG_TEST_STATUS, lcl_test, CHK_NO_CHANGE);
    endfunction

    function automatic void drop_bus_request();
        req_alarm  = 1'b0;
        req_test   = 1'b0;
        ignore_bus = 1'b1;
        set_delay(8'd0);
    endfunction

    // Update the state for one event and queue the message run it causes
    function automatic void predict_event(input t_in ev);
        logic [1:0] ans;
        logic       alarm_any;
        t_out       beat;
        run_buf.delete();
        case (ev.action)
            ACT_BUS_ALARM: begin
                req_alarm = ev.bus_value & BUS_BIT;
                if (!req_alarm && lcl_alarm && delay_cnt == 8'd0)
                    send_alarm_net();
                if (ignore_bus)
                    req_alarm = 1'b0;
            end
            ACT_BUS_TEST: begin
                req_test = ev.bus_value & BUS_BIT;
                if (!req_test && lcl_test)
                    send_test_net();
                if (ignore_bus)
                    req_test = 1'b0;
            end
            ACT_RESET: begin
                drop_bus_request();
            end
            ACT_STATUS: begin
                if (lcl_alarm != ev.alarm_local) begin
                    lcl_alarm = ev.alarm_local;
                    if (ev.alarm_local && flag_bits[SF_DELAYED]) begin
                        set_delay(delay_set);
                    end else begin
                        set_delay(8'd0);
                        send_alarm_net();
                    end
                    send_alarm_status();
                end
                if (lcl_test != ev.test_alarm_local) begin
                    lcl_test = ev.test_alarm_local;
                    send_test_net();
                    send_test_status();
                end
                bus_alarm_f = ev.alarm_from_bus;
                bus_test_f  = ev.test_alarm_from_bus;
            end
            ACT_BUTTON: begin
                if (req_alarm || req_test) begin
                    drop_bus_request();
                    add_msg(MSG_RESET, 1'b1, CHK_NO_CHANGE);
                end
            end
            ACT_SECOND: begin
                // counters wrap at 16 bits
                if (lcl_alarm) begin
                    if (delay_cnt != 8'd0) begin
                        set_delay(delay_cnt - 8'd1);
                        if (delay_cnt == 8'd0)
                            send_alarm_net();
                    end else if (flag_bits[SF_STATUS]) begin
                        stat_cnt = stat_cnt - 16'd1;
                        if (stat_cnt == 16'd0)
                            send_alarm_status();
                        if (flag_bits[SF_NETWORK]) begin
                            net_cnt = net_cnt - 16'd1;
                            if (net_cnt == 16'd0)
                                send_alarm_net();
                        end
                    end
                end else if (flag_bits[SF_IDLE]) begin
                    stat_cnt = stat_cnt - 16'd1;
                    if (stat_cnt == 16'd0)
                        send_alarm_status();
                end
                if (lcl_test && flag_bits[SF_TEST]) begin
                    test_cnt = test_cnt - 16'd1;
                    if (test_cnt == 16'd0) begin
                        if (flag_bits[SF_TEST_NET])
                            send_test_net();
                        send_test_status();
                    end
                end
            end
            ACT_MINUTE: begin
                if (ignore_bus && !(bus_alarm_f || bus_test_f)) begin
                    ignore_bus = 1'b0;
                    add_msg(MSG_RESET_VALUE, 1'b0, CHK_NO_CHANGE);
                end
            end
            default: begin
                ans = CHK_NO_CHANGE;
                if (req_alarm) begin
                    if (!bus_alarm_f)
                        ans = CHK_ALARM;
                end else if (req_test) begin
                    if (!bus_test_f)
                        ans = CHK_TEST;
                end else if (bus_alarm_f || bus_test_f) begin
                    ans = CHK_STOP;
                end
                add_msg(MSG_CHECK, 1'b0, ans);
            end
        endcase

        if (run_buf.size() == 0)
            add_msg(MSG_NONE, 1'b0, CHK_NO_CHANGE);

        alarm_any = lcl_alarm | bus_alarm_f | lcl_test | bus_test_f;
        foreach (run_buf[k]) begin
            beat.message_kind  = run_buf[k].kind;
            beat.message_value = run_buf[k].value;
            beat.check_answer  = run_buf[k].answer;
            beat.any_alarm     = alarm_any;
            beat.last          = (k == run_buf.size() - 1);
            awaited_msgs.push_back(beat);
        end
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Beats seen at each edge: reset, message out, register write, event in
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            restore_defaults();
            awaited_msgs.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_msgs.size() == 0) begin
                    mismatches++;
                    $display("%0t: message beat with none awaited, expected nothing, got %h",
                             $time, i_out);
                end else begin
                    want = awaited_msgs.pop_front();
                    check_field("message_kind", want.message_kind, i_out.message_kind);
                    check_field("message_value", want.message_value, i_out.message_value);
                    check_field("check_answer", want.check_answer, i_out.check_answer);
                    check_field("any_alarm", want.any_alarm, i_out.any_alarm);
                    check_field("last", want.last, i_out.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALARM_INTERVAL: begin
                        alarm_ival = i_cfg_data;
                        net_cnt    = i_cfg_data;
                        stat_cnt   = i_cfg_data;
                    end
                    CFG_TEST_INTERVAL: begin
                        test_ival = i_cfg_data;
                        test_cnt  = i_cfg_data;
                    end
                    CFG_ALARM_DELAY: begin
                        delay_set = i_cfg_data[7:0];
                    end
                    default: begin
                        flag_bits = i_cfg_data[5:0];
                    end
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_event(i_in);
        end
        o_outstanding <= awaited_msgs.size();
    end

endmodule

>>> sim/smoke_alarm_bus_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoke_alarm_bus_controller_unit_test
// Drives the alarm bus controller with directed events and then random event
// streams under several register settings, with random gaps on both sides, a
// long output hold-off and pauses until the message queue drains. The monitor
// beside the block checks every message; this module gives the verdict.
// ----------------------------------------------------------------------------

module smoke_alarm_bus_controller_unit_test;
    import sabc_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;

    int   fail_count;
    int   outstanding;
    bit   gaps_on = 1'b1;
    int   hold_requests = 0;
    int   holds_done = 0;
    int   quiet_cycles = 0;
    t_in  dev_now = '0;   // device status as last reported

    smoke_alarm_bus_controller_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data)
    );

    smoke_alarm_bus_controller_unit_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Message receiver: random stalls, or a long hold-off when asked
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= !(gaps_on && $urandom_range(99) < 17);
            end
        end
    end

    // Watchdog on cycles with no beat anywhere
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in make_event(input logic [2:0] act, input logic bv,
                                       input logic al, input logic tl,
                                       input logic ab, input logic tb);
        t_in ev;
        ev.action              = act;
        ev.bus_value           = bv;
        ev.alarm_local         = al;
        ev.test_alarm_local    = tl;
        ev.alarm_from_bus      = ab;
        ev.test_alarm_from_bus = tb;
        return ev;
    endfunction

    // Mostly second ticks and status reports that flip a flag now and then
    function automatic t_in random_event();
        t_in ev;
        int  pick;
        pick = $urandom_range(99);
        ev = make_event(ACT_CHECK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        if (pick < 35) begin
            ev.action = ACT_SECOND;
        end else if (pick < 55) begin
            ev = dev_now;
            ev.action = ACT_STATUS;
            ev.bus_value = 1'($urandom_range(1));
            if ($urandom_range(99) < 25) ev.alarm_local = !ev.alarm_local;
            if ($urandom_range(99) < 25) ev.test_alarm_local = !ev.test_alarm_local;
            if ($urandom_range(99) < 25) ev.alarm_from_bus = !ev.alarm_from_bus;
            if ($urandom_range(99) < 25) ev.test_alarm_from_bus = !ev.test_alarm_from_bus;
        end else if (pick < 63) begin
            ev.action = ACT_BUS_ALARM;
        end else if (pick < 71) begin
            ev.action = ACT_BUS_TEST;
        end else if (pick < 77) begin
            ev.action = ACT_RESET;
        end else if (pick < 84) begin
            ev.action = ACT_BUTTON;
        end else if (pick < 91) begin
            ev.action = ACT_MINUTE;
        end
        return ev;
    endfunction

    // One event beat; valid only drops in a random gap before the next event
    task automatic send_event(input t_in ev);
        while (gaps_on && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        if (ev.action == ACT_STATUS)
            dev_now = ev;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_event(random_event());
    endtask

    // Stop sending and let every awaited message come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] alarm_ival, input logic [15:0] test_ival,
                                input logic [7:0] delay_val, input logic [5:0] flags);
        wait_drained();
        repeat (3) @(posedge clk);
        write_reg(CFG_ALARM_INTERVAL, alarm_ival);
        write_reg(CFG_TEST_INTERVAL, test_ival);
        write_reg(CFG_ALARM_DELAY, {8'd0, delay_val});
        write_reg(CFG_SEND_FLAGS, {10'd0, flags});
        cfg_we <= 1'b0;
    endtask

    // Stimulus
    initial begin
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_ALARM_INTERVAL;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: bus requests, check answers, ignore and release
        send_event(make_event(ACT_CHECK,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_MINUTE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUTTON,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUS_ALARM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_CHECK,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_STATUS,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_event(make_event(ACT_CHECK,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(ACT_BUS_ALARM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_CHECK,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUS_TEST,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_STATUS,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_CHECK,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUTTON,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUS_ALARM, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_MINUTE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // full status change, then the send-on-clear paths
        send_event(make_event(ACT_STATUS,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(ACT_BUS_TEST,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_BUS_ALARM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_RESET,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_SECOND,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_STATUS,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

        // Delayed alarm: shown on, counted down, shown off with the net message
        program_regs(16'd3, 16'd2, 8'd3, 6'h3F);
        send_event(make_event(ACT_STATUS, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (3) send_event(make_event(ACT_SECOND, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        run_random(40);
        wait_drained();
        run_random(40);

        // Zero delay with the delayed flag: status only; then a long output hold-off
        program_regs(16'd1, 16'd1, 8'd0, 6'h3F);
        send_event(make_event(ACT_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(ACT_STATUS, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        hold_requests++;
        run_random(60);

        // Interval zero: counters wrap instead of sending
        program_regs(16'd0, 16'd0, 8'd0, 6'h3E);
        send_event(make_event(ACT_STATUS, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        repeat (3) send_event(make_event(ACT_SECOND, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));

        // Largest values, no gaps on either side
        gaps_on = 1'b0;
        program_regs(16'hFFFF, 16'hFFFF, 8'hFF, 6'h3F);
        run_random(60);
        gaps_on = 1'b1;

        // Random small settings
        repeat (3) begin
            program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                         8'($urandom_range(0, 5)), 6'($urandom_range(0, 63)));
            run_random(40);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/sabc_pkg.sv
sv/sabc_core.sv
sv/sabc_serializer.sv
sv/smoke_alarm_bus_controller_unit.sv
sim/smoke_alarm_bus_controller_unit_monitor.sv
sim/smoke_alarm_bus_controller_unit_test.sv
